/* rtl/stes_pkg.sv */
// Shared types and constants for the sorted table exponential search block.
package stes_pkg;

  localparam int KEY_W           = 32;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_EXP,
    ST_BSET,
    ST_BIN,
    ST_PUT
  } state_t;

endpackage

/* rtl/stes_if.sv */
// Valid/ready channel interfaces: input items, result items, entry count writes.
interface stes_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [stes_pkg::IDX_W-1:0]        entry_index;
  logic signed [stes_pkg::KEY_W-1:0] key_value;

  modport source (output valid, op, entry_index, key_value, input ready);
  modport sink   (input valid, op, entry_index, key_value, output ready);
endinterface

interface stes_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [stes_pkg::IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface stes_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [stes_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

/* rtl/stes_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/sorted_table_exponential_search.sv */
// Exponential search over a RAM table of ascending signed 32-bit keys.
//
// Channels:
//   in_ch  : items with op, entry_index, key_value. op write stores key_value at
//            entry_index (ignored when entry_index >= TABLE_DEPTH), no result.
//            op search looks for key_value and yields one result item.
//   out_ch : found flag and position (position is 0 on a miss).
//   cfg_ch : entry_count, ready outside reset; write it only while the block is idle.
// Sequence:
//   A write item is stored while the block stays idle; in_ch.ready stays high.
//   A search holds in_ch.ready low until its result is handed to the output
//   register; each probe is one RAM read checked by the one shared compare.
//   A search runs ST_ZERO (entry 0), ST_EXP (probe doubles while the entry is
//   below the key), ST_BSET (window from the final probe), ST_BIN (binary
//   probes) and ST_PUT, which returns to idle. An empty table goes straight to
//   ST_PUT; a hit on entry 0 goes from ST_ZERO to ST_PUT.
// Stall: the result waits in the output register while out_ch.ready is low;
//   write items keep flowing, a finished search waits in its hand-off state.
// Reset (rst_n low, synchronous): entry_count clears to 0, the sequencer goes
//   idle and the output register empties. The table itself is not cleared.
module sorted_table_exponential_search #(
  parameter int TABLE_DEPTH = stes_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stes_in_if.sink    in_ch,
  stes_out_if.source out_ch,
  stes_cfg_if.sink   cfg_ch
);

  localparam int KW = stes_pkg::KEY_W;
  localparam int IW = stes_pkg::IDX_W;
  localparam int CW = stes_pkg::CNT_W;
  // RAM address, clamped count, probe (reaches just under twice the count)
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int PW  = NW + 1;
  localparam int XCW = (CW > NW) ? CW : NW;
  localparam int XIW = (IW > NW) ? IW : NW;

  stes_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r;
  logic signed [KW-1:0] key_r, key_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [PW-1:0]        probe_r, probe_nxt;
  logic [NW-1:0]        lo_r, lo_nxt;
  logic [NW-1:0]        hi_r, hi_nxt;
  logic [NW-1:0]        mid_r, mid_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [IW-1:0]        out_pos_r, out_pos_nxt;

  logic                 in_acc;
  logic [XCW-1:0]       count_ext;
  logic [NW-1:0]        n_clamp;
  logic [XIW-1:0]       idx_ext;
  logic                 wr_en;
  logic [AW-1:0]        rd_addr;
  logic [KW-1:0]        rd_data;
  logic signed [KW-1:0] rd_key;
  logic                 key_eq, key_lt;
  logic [PW-1:0]        probe_dbl;
  logic [NW-1:0]        n_m1;
  logic [NW-1:0]        lo_set, hi_set, lo_up, hi_dn;

  assign in_ch.ready = rst_n && (state_r == stes_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  // count beyond the table depth acts as the depth
  assign count_ext = XCW'(count_r);
  assign n_clamp   = (count_ext > XCW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_ext);

  assign idx_ext = XIW'(in_ch.entry_index);
  assign wr_en   = in_acc && (in_ch.op == stes_pkg::OP_WRITE) &&
                   (idx_ext < XIW'(TABLE_DEPTH));

  stes_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(idx_ext)),
    .wr_data (in_ch.key_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the one shared comparator: table entry just read vs. search key
  assign rd_key = $signed(rd_data);
  assign key_eq = (rd_key == key_r);
  assign key_lt = (rd_key < key_r);

  assign probe_dbl = probe_r << 1;
  assign n_m1      = n_r - NW'(1);
  // binary window from the final probe
  assign lo_set    = NW'(probe_r >> 1);
  assign hi_set    = (probe_r < PW'(n_m1)) ? NW'(probe_r) : n_m1;
  assign lo_up     = mid_r + NW'(1);
  assign hi_dn     = mid_r - NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stes_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        count_r <= cfg_ch.entry_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    n_r         <= n_nxt;
    probe_r     <= probe_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    probe_nxt     = probe_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_addr       = '0;

    case (state_r)
      stes_pkg::ST_IDLE: begin
        if (in_acc && (in_ch.op == stes_pkg::OP_SEARCH)) begin
          key_nxt = in_ch.key_value;
          n_nxt   = n_clamp;
          rd_addr = '0;
          if (n_clamp == '0) begin
            found_nxt = 1'b0;
            pos_nxt   = '0;
            state_nxt = stes_pkg::ST_PUT;
          end else begin
            state_nxt = stes_pkg::ST_ZERO;
          end
        end
      end

      stes_pkg::ST_ZERO: begin
        probe_nxt = PW'(1);
        if (key_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = '0;
          state_nxt = stes_pkg::ST_PUT;
        end else if (PW'(1) < PW'(n_r)) begin
          rd_addr   = AW'(1);
          state_nxt = stes_pkg::ST_EXP;
        end else begin
          state_nxt = stes_pkg::ST_BSET;
        end
      end

      // entry at probe_r is on rd_data
      stes_pkg::ST_EXP: begin
        if (key_lt) begin
          probe_nxt = probe_dbl;
          if (probe_dbl < PW'(n_r)) begin
            rd_addr = AW'(probe_dbl);
          end else begin
            state_nxt = stes_pkg::ST_BSET;
          end
        end else begin
          state_nxt = stes_pkg::ST_BSET;
        end
      end

      stes_pkg::ST_BSET: begin
        lo_nxt    = lo_set;
        hi_nxt    = hi_set;
        mid_nxt   = NW'((PW'(lo_set) + PW'(hi_set)) >> 1);
        rd_addr   = AW'(mid_nxt);
        state_nxt = stes_pkg::ST_BIN;
      end

      // entry at mid_r is on rd_data; lo_r <= mid_r <= hi_r always
      stes_pkg::ST_BIN: begin
        if (key_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = IW'(mid_r);
          state_nxt = stes_pkg::ST_PUT;
        end else if (key_lt) begin
          if (mid_r == hi_r) begin
            found_nxt = 1'b0;
            pos_nxt   = '0;
            state_nxt = stes_pkg::ST_PUT;
          end else begin
            lo_nxt  = lo_up;
            mid_nxt = NW'((PW'(lo_up) + PW'(hi_r)) >> 1);
            rd_addr = AW'(mid_nxt);
          end
        end else begin
          if (mid_r == lo_r) begin
            found_nxt = 1'b0;
            pos_nxt   = '0;
            state_nxt = stes_pkg::ST_PUT;
          end else begin
            hi_nxt  = hi_dn;
            mid_nxt = NW'((PW'(lo_r) + PW'(hi_dn)) >> 1);
            rd_addr = AW'(mid_nxt);
          end
        end
      end

      // hand the result over once the output register is free
      stes_pkg::ST_PUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = pos_r;
          state_nxt     = stes_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/stes_chk.sv */
// Port-level checks for the exponential search block, bound to the top level.
module stes_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [stes_pkg::IDX_W-1:0] out_position
);

  // a result waiting for the receiver keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("result changed or dropped while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss with nonzero position");

  // a search occupies the block: no new item the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == stes_pkg::OP_SEARCH) |=> !in_ready)
    else $error("item taken during a search");

  // a write item never brings up a fresh result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == stes_pkg::OP_WRITE) && !out_valid |=> !out_valid)
    else $error("result after a write item");

endmodule

bind sorted_table_exponential_search stes_chk u_stes_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_found    (out_ch.found),
  .out_position (out_ch.position)
);
